/* sv/lzsm_pkg.sv */
// lzsm_pkg: shared types, symbol bases and class tables for the LZ token symbol mapper.
// Used by lzsm_map and lz_token_symbol_mapper_top. No dependencies.
package lzsm_pkg;

   typedef enum logic [1:0] {
      MODE_LITERAL  = 2'd0,
      MODE_LONG     = 2'd1,
      MODE_SHORT    = 2'd2,
      MODE_RESERVED = 2'd3
   } lzsm_mode_type;

   typedef struct packed {
      logic [8:0]  main_symbol;
      logic [2:0]  main_extra_count;
      logic [5:0]  main_extra_value;
      logic        has_distance;
      logic [5:0]  dist_symbol;
      logic [4:0]  dist_extra_count;
      logic [15:0] dist_extra_value;
   } lzsm_result_type;

   localparam logic [8:0]  LEN_BASE_SYM   = 9'd270;
   localparam logic [8:0]  SHORT_BASE_SYM = 9'd261;
   localparam logic [19:0] DIST_LIM_A     = 20'd64;
   localparam logic [19:0] DIST_LIM_B     = 20'd2048;
   localparam logic [19:0] DIST_LIM_C     = 20'd65536;
   localparam logic [19:0] DIST_LIM_D     = 20'd98304;
   localparam logic [19:0] DIST_LIM_E     = 20'd131072;
   localparam logic [5:0]  DIST_SYM_WIDE  = 6'd32;
   localparam logic [5:0]  DIST_SYM_MID   = 6'd33;
   localparam logic [7:0]  SHORT_LIM      = 8'd32;
   localparam logic [7:0]  LEN_LIM        = 8'd32;

   localparam logic [4:0] LEN_CLS_LO [0:31] = '{
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd9, 5'd9,
      5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13,
      5'd13, 5'd13, 5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15, 5'd15};

   localparam logic [4:0] LEN_CLS_HI [0:31] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd20, 5'd21,
      5'd21, 5'd22, 5'd22, 5'd23, 5'd23, 5'd24, 5'd24, 5'd24, 5'd24, 5'd25,
      5'd25, 5'd25, 5'd25, 5'd26, 5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27,
      5'd27};

   localparam logic [2:0] LEN_XBITS [0:27] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5};

   localparam logic [4:0] DST_CLS_A [0:63] = '{
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd4, 5'd5, 5'd5,
      5'd6, 5'd6, 5'd6, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7,
      5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
      5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9,
      5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
      5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
      5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
      5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11};

   localparam logic [4:0] DST_CLS_B [0:63] = '{
      5'd0, 5'd0, 5'd12, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15,
      5'd16, 5'd16, 5'd16, 5'd16, 5'd17, 5'd17, 5'd17, 5'd17,
      5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
      5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
      5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
      5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
      5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
      5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21};

   localparam logic [4:0] DST_CLS_C [0:63] = '{
      5'd0, 5'd0, 5'd22, 5'd23, 5'd24, 5'd24, 5'd25, 5'd25,
      5'd26, 5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
      5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
      5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29,
      5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
      5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
      5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
      5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31};

   localparam logic [4:0] DST_XBITS [0:47] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2, 5'd3, 5'd3, 5'd4, 5'd4,
      5'd5, 5'd5, 5'd6, 5'd6, 5'd7, 5'd7, 5'd8, 5'd8, 5'd9, 5'd9, 5'd10, 5'd10,
      5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15,
      5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
      5'd16, 5'd16, 5'd16, 5'd16};

   localparam logic [2:0] SH_CLS [0:31] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3};

   localparam logic [2:0] SH_XBITS [0:7] = '{
      3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6};

endpackage

/* sv/lzsm_map.sv */
// lzsm_map: combinational token-to-symbol mapping for one registered token.
// Depends on lzsm_pkg (mode and result types, class tables).
module lzsm_map (
   input  lzsm_pkg::lzsm_mode_type   mode,
   input  logic [7:0]                byte_or_length,
   input  logic [19:0]               distance,
   output lzsm_pkg::lzsm_result_type result
);
   import lzsm_pkg::*;

   logic [4:0]  len_cls;
   logic [2:0]  len_nb;
   logic [6:0]  len_mask;
   logic [5:0]  dsym;
   logic [4:0]  dst_nb;
   logic [16:0] dst_mask;
   logic [7:0]  sh_dist;
   logic [2:0]  sh_cls_n;
   logic [2:0]  sh_nb;
   logic [6:0]  sh_mask;

   always_comb begin
      if (byte_or_length < LEN_LIM) begin
         len_cls = LEN_CLS_LO[byte_or_length[4:0]];
      end else begin
         len_cls = LEN_CLS_HI[byte_or_length[7:3]];
      end
      len_nb   = LEN_XBITS[len_cls];
      len_mask = (7'd1 << len_nb) - 7'd1;
   end

   always_comb begin
      if (distance < DIST_LIM_A) begin
         dsym = {1'b0, DST_CLS_A[distance[5:0]]};
      end else if (distance < DIST_LIM_B) begin
         dsym = {1'b0, DST_CLS_B[distance[10:5]]};
      end else if (distance < DIST_LIM_C) begin
         dsym = {1'b0, DST_CLS_C[distance[15:10]]};
      end else if (distance < DIST_LIM_D) begin
         dsym = DIST_SYM_WIDE;
      end else if (distance < DIST_LIM_E) begin
         dsym = DIST_SYM_MID;
      end else begin
         dsym = DIST_SYM_WIDE + {2'b00, distance[19:16]};
      end
      dst_nb   = DST_XBITS[dsym];
      dst_mask = (17'd1 << dst_nb) - 17'd1;
   end

   always_comb begin
      sh_dist = distance[7:0];
      if (sh_dist < SHORT_LIM) begin
         sh_cls_n = SH_CLS[sh_dist[4:0]];
      end else begin
         sh_cls_n = {1'b1, sh_dist[7:6]};
      end
      sh_nb   = SH_XBITS[sh_cls_n];
      sh_mask = (7'd1 << sh_nb) - 7'd1;
   end

   always_comb begin
      result = '0;
      case (mode)
         MODE_LITERAL: begin
            result.main_symbol = {1'b0, byte_or_length};
         end
         MODE_LONG: begin
            result.main_symbol      = LEN_BASE_SYM + {4'd0, len_cls};
            result.main_extra_count = len_nb;
            result.main_extra_value = byte_or_length[5:0] & len_mask[5:0];
            result.has_distance     = 1'b1;
            result.dist_symbol      = dsym;
            result.dist_extra_count = dst_nb;
            result.dist_extra_value = distance[15:0] & dst_mask[15:0];
         end
         MODE_SHORT: begin
            result.main_symbol      = SHORT_BASE_SYM + {6'd0, sh_cls_n};
            result.main_extra_count = sh_nb;
            result.main_extra_value = sh_dist[5:0] & sh_mask[5:0];
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

/* sv/lz_token_symbol_mapper_top.sv */
// lz_token_symbol_mapper_top: token input register, lzsm_map, result register.
// Depends on lzsm_pkg and lzsm_map.
// A beat goes through the token register and the result register to rsp_.
// Throughput: one token per cycle unless rsp_stall backs up a full pipeline.
// Tokens of the reserved mode are accepted and dropped without a result.
// Reset (synchronous) clears both stage valid flags; payload registers are not reset.
module lz_token_symbol_mapper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_byte_or_length,
   input  logic [19:0] req_distance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_main_symbol,
   output logic [2:0]  rsp_main_extra_count,
   output logic [5:0]  rsp_main_extra_value,
   output logic        rsp_has_distance,
   output logic [5:0]  rsp_dist_symbol,
   output logic [4:0]  rsp_dist_extra_count,
   output logic [15:0] rsp_dist_extra_value
);
   import lzsm_pkg::*;

   logic            tok_valid_ff, tok_valid_in;
   lzsm_mode_type   tok_mode_ff;
   logic [7:0]      tok_bl_ff;
   logic [19:0]     tok_dist_ff;
   logic            res_valid_ff, res_valid_in;
   lzsm_result_type res_ff;
   lzsm_result_type map_result;
   logic            res_load;
   logic            tok_load;

   lzsm_map u_map (
      .mode           (tok_mode_ff),
      .byte_or_length (tok_bl_ff),
      .distance       (tok_dist_ff),
      .result         (map_result)
   );

   always_comb begin
      res_load     = !res_valid_ff || !rsp_stall;
      tok_load     = !tok_valid_ff || res_load;
      req_stall    = !tok_load;
      tok_valid_in = tok_load ? (req_valid && (req_mode != MODE_RESERVED)) : tok_valid_ff;
      res_valid_in = res_load ? tok_valid_ff : res_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_load && req_valid) begin
         tok_mode_ff <= lzsm_mode_type'(req_mode);
         tok_bl_ff   <= req_byte_or_length;
         tok_dist_ff <= req_distance;
      end
      if (res_load && tok_valid_ff) begin
         res_ff <= map_result;
      end
   end

   assign rsp_valid            = res_valid_ff;
   assign rsp_main_symbol      = res_ff.main_symbol;
   assign rsp_main_extra_count = res_ff.main_extra_count;
   assign rsp_main_extra_value = res_ff.main_extra_value;
   assign rsp_has_distance     = res_ff.has_distance;
   assign rsp_dist_symbol      = res_ff.dist_symbol;
   assign rsp_dist_extra_count = res_ff.dist_extra_count;
   assign rsp_dist_extra_value = res_ff.dist_extra_value;

   a_stall_needs_token: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (tok_valid_ff && res_valid_ff && rsp_stall))
      else $error("input stalled without a blocked pipeline");

   a_dist_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_distance) |->
         (rsp_dist_symbol == 6'd0 && rsp_dist_extra_count == 5'd0 &&
          rsp_dist_extra_value == 16'd0))
      else $error("distance fields set without a distance symbol");

   a_long_symbol_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_distance) |-> (rsp_main_symbol >= LEN_BASE_SYM))
      else $error("long match with a main symbol below the length base");

   a_main_extra_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_main_extra_value >> rsp_main_extra_count) == 6'd0))
      else $error("main extra value wider than its count");

   a_reserved_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == MODE_RESERVED) |=> !tok_valid_ff)
      else $error("reserved-mode token entered the pipeline");

endmodule
